>>> design/toy_isa_execute_unit_top_macros.svh
// Assertion macros shared by the execute unit RTL
`ifndef TOY_ISA_EXECUTE_UNIT_TOP_MACROS_SVH
`define TOY_ISA_EXECUTE_UNIT_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, checked out of reset
`define TIE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication, checked out of reset
`define TIE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TIE_ASSERT_IMP(lbl, ante, cons)
`define TIE_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

>>> design/tie_pkg.sv
// Shared types, constants and the instruction decoder of the execute unit
package tie_pkg;

  // defaults for the top level parameters
  localparam int unsigned REG_COUNT_DEF  = 32;
  localparam int unsigned DATA_WIDTH_DEF = 32;

  // register number width, fixed by the instruction formats
  localparam int unsigned IDX_W = 5;

  // leading zero counts that select a format
  localparam int unsigned ZC_ALU  = 14;
  localparam int unsigned ZC_MOVE = 19;
  localparam int unsigned ZC_JUMP = 23;

  // flag registers
  localparam logic [IDX_W-1:0] FLAG_GT = 5'd17;
  localparam logic [IDX_W-1:0] FLAG_EQ = 5'd18;

  // operations; each group is laid out so the opcode field indexes into it
  typedef enum logic [4:0] {
    OP_ADD     = 5'd0,
    OP_SUB     = 5'd1,
    OP_MUL     = 5'd2,
    OP_DIV     = 5'd3,
    OP_MOV     = 5'd4,
    OP_MOVI    = 5'd5,
    OP_CMP     = 5'd6,
    OP_CMPI    = 5'd7,
    OP_JEQ     = 5'd8,
    OP_JMP     = 5'd9,
    OP_JLT     = 5'd10,
    OP_JGT     = 5'd11,
    OP_INC     = 5'd12,
    OP_DEC     = 5'd13,
    OP_JNE     = 5'd14,
    OP_ILLEGAL = 5'd15,
    OP_HALT    = 5'd16
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_ITER,
    ST_DONE
  } state_t;

  // decoded instruction
  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
    logic [IDX_W-1:0] idx_d;
    logic [IDX_W-1:0] imm;
  } dec_t;

  // register file read request
  typedef struct packed {
    logic [IDX_W-1:0] idx_a;
    logic [IDX_W-1:0] idx_b;
  } rf_rd_t;

  // register file write request (data travels alongside)
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } rf_wr_t;

  // multiply/divide unit control and status
  typedef struct packed {
    logic start;
    logic is_div;
  } md_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } md_stat_t;

  // format and operand selection from the raw word
  function automatic dec_t tie_decode(input logic [31:0] w);
    dec_t d;
    d.op    = OP_ILLEGAL;
    d.idx_a = w[9:5];
    d.idx_b = w[4:0];
    d.idx_d = w[4:0];
    d.imm   = w[9:5];
    if (w[31]) begin
      d.op = OP_HALT;
    end else if (w[31 -: ZC_ALU] == '0 && w[31 - ZC_ALU]) begin
      d.op    = op_t'({3'b000, w[16:15]});
      d.idx_d = w[14:10];
    end else if (w[31 -: ZC_MOVE] == '0 && w[31 - ZC_MOVE]) begin
      d.op = op_t'({3'b001, w[11:10]});
    end else if (w[31 -: ZC_JUMP] == '0 && w[31 - ZC_JUMP]) begin
      d.op = op_t'({2'b01, w[7:5]});
      if (d.op == OP_INC || d.op == OP_DEC) begin
        d.idx_a = w[4:0];
      end else begin
        d.idx_a = FLAG_GT;
        d.idx_b = FLAG_EQ;
      end
      d.imm = w[4:0];
    end
    return d;
  endfunction

endpackage

>>> design/tie_if.sv
// Instruction and result channel interfaces
interface tie_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface tie_out_if;
  logic               valid;
  logic               ready;
  logic               halted;
  logic               illegal;
  logic               jump_taken;
  logic [4:0]         jump_target;
  logic               write_enable;
  logic [4:0]         write_index;
  logic signed [31:0] write_value;

  modport source (output valid, output halted, output illegal, output jump_taken,
                  output jump_target, output write_enable, output write_index,
                  output write_value, input ready);
  modport sink   (input valid, input halted, input illegal, input jump_taken,
                  input jump_target, input write_enable, input write_index,
                  input write_value, output ready);
endinterface

>>> design/tie_ram.sv
// Generic RAM: one write port, two registered read ports
module tie_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> design/tie_regfile.sv
// Register file: RAM plus per-entry valid bits so unwritten entries read as zero
module tie_regfile
  import tie_pkg::*;
#(
  parameter int unsigned REG_COUNT  = REG_COUNT_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rf_rd_t                rd_req,
  output logic [DATA_WIDTH-1:0] rd_a,
  output logic [DATA_WIDTH-1:0] rd_b,
  input  rf_wr_t                wr_req,
  input  logic [DATA_WIDTH-1:0] wr_data
);

  localparam int unsigned AW = $clog2(REG_COUNT);

  logic [REG_COUNT-1:0]  valid_r;
  logic                  ok_a_r, ok_b_r;
  logic                  in_a, in_b, in_w;
  logic [DATA_WIDTH-1:0] ram_a, ram_b;

  // register numbers beyond the file read as zero and are never written
  assign in_a = {1'b0, rd_req.idx_a} < (IDX_W+1)'(REG_COUNT);
  assign in_b = {1'b0, rd_req.idx_b} < (IDX_W+1)'(REG_COUNT);
  assign in_w = {1'b0, wr_req.idx} < (IDX_W+1)'(REG_COUNT);

  tie_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (REG_COUNT)
  ) u_ram (
    .clk     (clk),
    .we      (wr_req.en && in_w),
    .waddr   (wr_req.idx[AW-1:0]),
    .wdata   (wr_data),
    .raddr_a (rd_req.idx_a[AW-1:0]),
    .raddr_b (rd_req.idx_b[AW-1:0]),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  // valid bits; cleared at reset, set on first write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_req.en && in_w) begin
      valid_r[wr_req.idx[AW-1:0]] <= 1'b1;
    end
  end

  // qualifiers aligned with the registered read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_a_r <= 1'b0;
      ok_b_r <= 1'b0;
    end else begin
      ok_a_r <= in_a && valid_r[rd_req.idx_a[AW-1:0]];
      ok_b_r <= in_b && valid_r[rd_req.idx_b[AW-1:0]];
    end
  end

  assign rd_a = ok_a_r ? ram_a : '0;
  assign rd_b = ok_b_r ? ram_b : '0;

endmodule

>>> design/tie_muldiv.sv
// Iterative multiply (shift-add) and signed divide (restoring), one bit per cycle
module tie_muldiv
  import tie_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  md_ctrl_t              ctrl,
  input  logic [DATA_WIDTH-1:0] opa,
  input  logic [DATA_WIDTH-1:0] opb,
  output md_stat_t              stat,
  output logic [DATA_WIDTH-1:0] res
);

  localparam int unsigned CW = $clog2(DATA_WIDTH + 1);

  logic                  busy_r, done_r;
  logic                  div_r, neg_r, dz_r;
  logic [CW-1:0]         cnt_r;
  logic [DATA_WIDTH-1:0] opnd_r;   // divisor or multiplicand
  logic [DATA_WIDTH-1:0] work_r;   // dividend/quotient or multiplier
  logic [DATA_WIDTH-1:0] acc_r;    // remainder or product
  logic [DATA_WIDTH-1:0] mag_a, mag_b;
  logic [DATA_WIDTH:0]   trial, diff;
  logic                  ge;

  // operand magnitudes for the divide
  assign mag_a = opa[DATA_WIDTH-1] ? -opa : opa;
  assign mag_b = opb[DATA_WIDTH-1] ? -opb : opb;

  // restoring divide step
  assign trial = {acc_r, work_r[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, opnd_r};
  assign ge    = trial >= {1'b0, opnd_r};

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= busy_r && cnt_r == CW'(1);
      if (ctrl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DATA_WIDTH);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      div_r  <= ctrl.is_div;
      neg_r  <= opa[DATA_WIDTH-1] ^ opb[DATA_WIDTH-1];
      dz_r   <= ctrl.is_div && opb == '0;
      opnd_r <= ctrl.is_div ? mag_b : opa;
      work_r <= ctrl.is_div ? mag_a : opb;
      acc_r  <= '0;
    end else if (busy_r) begin
      if (div_r) begin
        acc_r  <= ge ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
        work_r <= {work_r[DATA_WIDTH-2:0], ge};
      end else begin
        acc_r  <= acc_r + (work_r[0] ? opnd_r : '0);
        opnd_r <= {opnd_r[DATA_WIDTH-2:0], 1'b0};
        work_r <= {1'b0, work_r[DATA_WIDTH-1:1]};
      end
    end
  end

  // quotient sign fix-up; divide by zero gives zero
  always_comb begin
    if (!div_r) begin
      res = acc_r;
    end else if (dz_r) begin
      res = '0;
    end else begin
      res = neg_r ? -work_r : work_r;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

>>> design/toy_isa_execute_unit_top.sv
// Execute unit for the toy instruction set.
//
// in_ch carries one 32-bit instruction word per transaction; out_ch returns
// exactly one result transaction per instruction (halt, illegal, jump and
// register-write report). Both use valid/ready; a transaction completes on a
// rising clk edge with valid and ready high.
// Architectural state is a register file held in a RAM with registered reads;
// registers 17 and 18 are the greater and equal flags.
// Each instruction is read, executed and written back in turn: it is taken in
// ST_IDLE, its operands are read in ST_READ, it executes in ST_EXEC and its
// result is loaded into the output register in ST_DONE; the next instruction is
// taken only back in ST_IDLE. mul and div go through a shared one-bit-per-cycle
// unit and wait in ST_ITER until it is done.
// rst_n (synchronous, active low) clears the sequencer, the output valid flag
// and the register file valid bits, so every register reads as zero.
// If out_ch stalls, a finished result waits in the output register while the
// next instruction is taken and executed; that one then holds before write-back
// (bar the greater flag of a compare) until the output register is free.
module toy_isa_execute_unit_top
  import tie_pkg::*;
#(
  parameter int unsigned REG_COUNT  = REG_COUNT_DEF,
  parameter int unsigned DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic clk,
  input logic rst_n,
  tie_in_if.sink    in_ch,
  tie_out_if.source out_ch
);

`include "toy_isa_execute_unit_top_macros.svh"

  state_t                state_r, state_nxt;
  dec_t                  dec_r;
  rf_rd_t                rf_rd;
  rf_wr_t                rf_wr;
  logic [DATA_WIDTH-1:0] rf_wdata;
  logic [DATA_WIDTH-1:0] oa, ob;
  md_ctrl_t              md_ctrl;
  md_stat_t              md_stat;
  logic [DATA_WIDTH-1:0] md_res;

  // execute results
  logic [DATA_WIDTH-1:0] res_r;
  logic                  we_r, jt_r, halt_r, ill_r, eq_r;
  logic [IDX_W-1:0]      widx_r;

  // output register
  logic                  out_valid_r;
  logic                  o_halted_r, o_illegal_r, o_jt_r, o_we_r;
  logic [IDX_W-1:0]      o_target_r, o_widx_r;
  logic [31:0]           o_wval_r;

  logic                  accept, out_free, load_out, is_cmp, is_md;
  logic [63:0]           wval_ext;

  // combinational execute
  logic [DATA_WIDTH-1:0] imm_ext, lhs, ex_val;
  logic                  eq, gt, ex_we, ex_jt, ex_halt, ex_ill;
  logic [IDX_W-1:0]      ex_idx;

  assign accept   = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign is_cmp   = dec_r.op == OP_CMP || dec_r.op == OP_CMPI;
  assign is_md    = dec_r.op == OP_MUL || dec_r.op == OP_DIV;
  assign load_out = state_r == ST_DONE && out_free;

  // register file and iterative unit
  assign rf_rd.idx_a = dec_r.idx_a;
  assign rf_rd.idx_b = dec_r.idx_b;

  tie_regfile #(
    .REG_COUNT  (REG_COUNT),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_req  (rf_rd),
    .rd_a    (oa),
    .rd_b    (ob),
    .wr_req  (rf_wr),
    .wr_data (rf_wdata)
  );

  tie_muldiv #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (md_ctrl),
    .opa   (oa),
    .opb   (ob),
    .stat  (md_stat),
    .res   (md_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_READ;
      ST_READ: state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = is_md ? ST_ITER : ST_DONE;
      ST_ITER: if (md_stat.done) state_nxt = ST_DONE;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // sequencer outputs: handshake, unit start, write-back
  always_comb begin
    in_ch.ready    = state_r == ST_IDLE;
    md_ctrl.start  = state_r == ST_EXEC && is_md;
    md_ctrl.is_div = dec_r.op == OP_DIV;
    rf_wr.en       = 1'b0;
    rf_wr.idx      = widx_r;
    rf_wdata       = res_r;
    case (state_r)
      ST_EXEC: begin
        // compare writes the greater flag first
        if (is_cmp) begin
          rf_wr.en  = 1'b1;
          rf_wr.idx = FLAG_GT;
          rf_wdata  = DATA_WIDTH'(gt);
        end
      end
      ST_DONE: begin
        if (out_free) begin
          if (is_cmp) begin
            rf_wr.en  = 1'b1;
            rf_wr.idx = FLAG_EQ;
            rf_wdata  = DATA_WIDTH'(eq_r);
          end else begin
            rf_wr.en = we_r;
          end
        end
      end
      default: ;
    endcase
  end

  // decode on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      dec_r <= tie_decode(in_ch.instr_word);
    end
  end

  // execute: operands arrive from the register file in ST_EXEC
  always_comb begin
    imm_ext = DATA_WIDTH'(dec_r.imm);
    lhs     = (dec_r.op == OP_CMP) ? oa : imm_ext;
    eq      = lhs == ob;
    gt      = !eq && ($signed(lhs) > $signed(ob));
    ex_we   = 1'b0;
    ex_jt   = 1'b0;
    ex_halt = 1'b0;
    ex_ill  = 1'b0;
    ex_idx  = dec_r.idx_d;
    ex_val  = '0;
    case (dec_r.op)
      OP_ADD:  begin ex_we = 1'b1; ex_val = oa + ob; end
      OP_SUB:  begin ex_we = 1'b1; ex_val = oa - ob; end
      OP_MUL:  ex_we = 1'b1;
      OP_DIV:  ex_we = 1'b1;
      OP_MOV:  begin ex_we = 1'b1; ex_val = oa; end
      OP_MOVI: begin ex_we = 1'b1; ex_val = imm_ext; end
      OP_CMP, OP_CMPI: begin
        ex_we  = 1'b1;
        ex_idx = gt ? FLAG_GT : FLAG_EQ;
        ex_val = DATA_WIDTH'(gt || eq);
      end
      // flags: oa is greater, ob is equal
      OP_JEQ:  ex_jt = ob == DATA_WIDTH'(1);
      OP_JMP:  ex_jt = 1'b1;
      OP_JLT:  ex_jt = oa == DATA_WIDTH'(1);
      OP_JGT:  ex_jt = ob == '0 && oa == '0;
      OP_JNE:  ex_jt = ob != DATA_WIDTH'(1);
      OP_INC:  begin ex_we = 1'b1; ex_val = oa + DATA_WIDTH'(1); end
      OP_DEC:  begin ex_we = 1'b1; ex_val = oa - DATA_WIDTH'(1); end
      OP_HALT: ex_halt = 1'b1;
      default: ex_ill = 1'b1;
    endcase
    // writes beyond the file are dropped and not reported
    if ({1'b0, ex_idx} >= (IDX_W+1)'(REG_COUNT)) begin
      ex_we = 1'b0;
    end
  end

  // capture execute results; mul/div result arrives later
  always_ff @(posedge clk) begin
    if (state_r == ST_EXEC) begin
      we_r   <= ex_we;
      widx_r <= ex_we ? ex_idx : '0;
      res_r  <= ex_we ? ex_val : '0;
      jt_r   <= ex_jt;
      halt_r <= ex_halt;
      ill_r  <= ex_ill;
      eq_r   <= eq;
    end else if (state_r == ST_ITER && md_stat.done) begin
      res_r  <= we_r ? md_res : '0;
    end
  end

  // result register
  assign wval_ext = 64'($signed(res_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_halted_r  <= halt_r;
      o_illegal_r <= ill_r;
      o_jt_r      <= jt_r;
      o_target_r  <= jt_r ? dec_r.imm : '0;
      o_we_r      <= we_r;
      o_widx_r    <= widx_r;
      o_wval_r    <= wval_ext[31:0];
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.halted       = o_halted_r;
  assign out_ch.illegal      = o_illegal_r;
  assign out_ch.jump_taken   = o_jt_r;
  assign out_ch.jump_target  = o_target_r;
  assign out_ch.write_enable = o_we_r;
  assign out_ch.write_index  = o_widx_r;
  assign out_ch.write_value  = o_wval_r;

  // checks
  `TIE_ASSERT_NXT(a_accept_reads, accept, state_r == ST_READ)
  `TIE_ASSERT_IMP(a_md_done_in_iter, md_stat.done, state_r == ST_ITER)
  `TIE_ASSERT_IMP(a_md_start_idle, md_ctrl.start, !md_stat.busy)
  `TIE_ASSERT_IMP(a_no_write_zero, out_valid_r && !o_we_r, o_widx_r == '0 && o_wval_r == '0)
  `TIE_ASSERT_IMP(a_stop_quiet, out_valid_r && (o_halted_r || o_illegal_r), !o_we_r && !o_jt_r && !(o_halted_r && o_illegal_r))

endmodule
